// ===== rtl/ple_pkg.sv =====
// positional list engine: shared types and codes
// used by every module of the block; depends on nothing
`default_nettype none

package ple_pkg;

    // width of a list index and of the position field
    localparam int IDX_W = 6;

    // operation codes carried in the func field
    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_AT    = 3'd5,
        FN_READ_AT   = 3'd6
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // what every cell does with its entry
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_DELETE = 2'd2,
        SH_READ   = 2'd3
    } t_shift;

    // input beat
    typedef struct packed {
        logic [2:0]          func;
        logic signed [31:0]  item_value;
        logic [IDX_W-1:0]    position;
    } t_in;

    // result beat
    typedef struct packed {
        t_status             status;
        logic [4:0]          entry_count;
        logic signed [31:0]  read_value;
    } t_out;

    // command broadcast to the row of cells
    typedef struct packed {
        t_shift              op;
        logic [IDX_W-1:0]    idx;
        logic signed [31:0]  value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
// positional list engine: one storage cell of the row
// holds one list entry and trades it with its neighbors; uses ple_pkg
`default_nettype none

module ple_cell #(
    parameter int INDEX = 0
) (
    input  wire                        i_clk,
    input  ple_pkg::t_cell_cmd         i_cmd,
    input  wire logic signed [31:0]    i_left,
    input  wire logic signed [31:0]    i_right,
    output logic signed [31:0]         o_data,
    output logic signed [31:0]         o_rd
);
    import ple_pkg::*;

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               hit;
    logic               above;

    assign hit   = (i_cmd.idx == IDX_W'(INDEX));
    assign above = (IDX_W'(INDEX) > i_cmd.idx);

    // next entry: load, take from a neighbor or hold
    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            SH_INSERT: begin
                if (hit) begin
                    n_data = i_cmd.value;
                end else if (above) begin
                    n_data = i_left;
                end
            end
            SH_DELETE: begin
                if (hit || above) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

    // read tap, zero unless this cell is addressed
    assign o_rd = (i_cmd.op == SH_READ && hit) ? r_data : 32'sd0;

endmodule

`default_nettype wire

// ===== rtl/ple_decode.sv =====
// positional list engine: operation decode and range checks
// turns one input beat and the count into a cell command; uses ple_pkg
`default_nettype none

module ple_decode #(
    parameter int DEPTH = 16,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  ple_pkg::t_in               i_item,
    input  wire logic [CNT_W-1:0]      i_count,
    output ple_pkg::t_cell_cmd         o_cmd,
    output ple_pkg::t_status           o_status,
    output logic [CNT_W-1:0]           o_count
);
    import ple_pkg::*;

    logic [IDX_W:0] pos_x;
    logic [IDX_W:0] cnt_x;
    logic           full;
    logic           empty;
    logic           pos_ins_bad;
    logic           pos_bad;

    // widened compares so count plus one never wraps
    assign pos_x       = (IDX_W + 1)'(i_item.position);
    assign cnt_x       = (IDX_W + 1)'(i_count);
    assign full        = (cnt_x >= (IDX_W + 1)'(DEPTH));
    assign empty       = (cnt_x == '0);
    assign pos_ins_bad = (pos_x == '0) || (pos_x > cnt_x + 1'b1);
    assign pos_bad     = (pos_x == '0) || (pos_x > cnt_x);

    // per-operation command, status and count
    always_comb begin
        o_cmd.op    = SH_HOLD;
        o_cmd.idx   = '0;
        o_cmd.value = i_item.item_value;
        o_status    = ST_DONE;
        o_count     = i_count;
        unique case (i_item.func)
            FN_INS_FRONT, FN_INS_BACK: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.op  = SH_INSERT;
                    o_cmd.idx = (i_item.func == FN_INS_FRONT) ? '0 : IDX_W'(i_count);
                    o_count   = i_count + 1'b1;
                end
            end
            FN_INS_AT: begin
                if (pos_ins_bad) begin
                    o_status = ST_BADPOS;
                end else if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.op  = SH_INSERT;
                    o_cmd.idx = i_item.position - 1'b1;
                    o_count   = i_count + 1'b1;
                end
            end
            FN_DEL_FRONT, FN_DEL_BACK: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_cmd.op  = SH_DELETE;
                    o_cmd.idx = (i_item.func == FN_DEL_FRONT) ? '0
                                : IDX_W'(i_count - 1'b1);
                    o_count   = i_count - 1'b1;
                end
            end
            FN_DEL_AT: begin
                if (pos_bad) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_cmd.op  = SH_DELETE;
                    o_cmd.idx = i_item.position - 1'b1;
                    o_count   = i_count - 1'b1;
                end
            end
            FN_READ_AT: begin
                if (pos_bad) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_cmd.op  = SH_READ;
                    o_cmd.idx = i_item.position - 1'b1;
                end
            end
            default: o_status = ST_DONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_top.sv =====
// positional list engine: top level with the cell row and result register
// instantiates ple_decode and ple_cell; uses ple_pkg
//
// usage
//   input channel: i_in_valid / o_in_stall / i_in_data carry one operation
//   per beat (insert front/back/at, delete front/back/at, read at).
//   output channel: o_out_valid / i_out_stall / o_out_data carry one result
//   beat per input beat: status, count after the operation, read value.
//   latency: the result is valid in the cycle after the input beat is taken.
//   throughput: one operation per unstalled cycle; every cell compares its
//   index with the decoded position and shifts, loads or holds in that cycle.
//   stall: while a result waits under i_out_stall the input is stalled;
//   when the result is taken in a cycle, a new beat is taken in that cycle.
//   reset: i_rst_n low clears the count and the result valid flag, so the
//   list is empty; no clearing pass is needed and the block is ready at once.
//   DEPTH sets the number of cells (2..63); entry_count is the low five bits
//   of the count.
`default_nettype none

module positional_list_engine_top #(
    parameter int DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  ple_pkg::t_in      i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output ple_pkg::t_out     o_out_data
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic               r_out_valid;
    logic               n_out_valid;
    t_out               r_out;
    t_out               n_out;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   dec_count;
    t_status            dec_status;
    t_cell_cmd          dec_cmd;
    t_cell_cmd          cell_cmd;
    logic               accept;
    logic signed [31:0] cell_data [DEPTH];
    logic signed [31:0] cell_rd   [DEPTH];
    logic signed [31:0] rd_value;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    ple_decode #(
        .DEPTH (DEPTH)
    ) u_decode (
        .i_item   (i_in_data),
        .i_count  (r_count),
        .o_cmd    (dec_cmd),
        .o_status (dec_status),
        .o_count  (dec_count)
    );

    // cells move only on a taken beat
    always_comb begin
        cell_cmd = dec_cmd;
        if (!accept) begin
            cell_cmd.op = SH_HOLD;
        end
    end

    // row of cells, each wired to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = 32'sd0;
        end else begin : g_inner_l
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner_r
            assign right_data = cell_data[g+1];
        end

        ple_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g]),
            .o_rd    (cell_rd[g])
        );
    end

    // merge the read taps, at most one is nonzero
    always_comb begin
        rd_value = 32'sd0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_value = rd_value | cell_rd[k];
        end
    end

    // next count and result beat
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (accept) begin
            n_count                 = dec_count;
            n_out_valid             = 1'b1;
            n_out.status            = dec_status;
            n_out.entry_count       = 5'(dec_count);
            n_out.read_value        = rd_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the count never passes the cell row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    // a taken beat moves the count by at most one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)
                   || (r_count == $past(r_count) - 1'b1))
        else $error("count jumped");

    // a taken beat always yields a result beat
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("result beat missing");

    // an empty status only ever reports an empty list
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> (r_out.entry_count == 5'd0))
        else $error("empty status with entries held");

    // a full status reports a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> (r_out.entry_count == 5'(DEPTH)))
        else $error("full status below depth");

endmodule

`default_nettype wire
